// ===== rtl/led_dimmer_fade_controller_assert.svh =====
// Assertion macros shared by the LED dimmer RTL.
`ifndef LED_DIMMER_FADE_CONTROLLER_ASSERT_SVH
`define LED_DIMMER_FADE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LDF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ldf: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define LDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ldf: next-cycle check failed");

`endif

// ===== rtl/ldf_pkg.sv =====
// Shared types and constants for the LED dimmer fade controller.
package ldf_pkg;

  // Fixed point of the brightness values
  localparam int FRAC_BITS = 12;
  localparam int BRT_W     = 12;
  localparam int WIDE_W    = 16;

  // Event opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_ENC    = 2'd2;

  // Strip states
  localparam logic [1:0] ST_OFF  = 2'd0;
  localparam logic [1:0] ST_ON   = 2'd1;
  localparam logic [1:0] ST_FADE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_BRT_MIN   = 3'd0;
  localparam logic [2:0] REG_BRT_MAX   = 3'd1;
  localparam logic [2:0] REG_ENC_STEP  = 3'd2;
  localparam logic [2:0] REG_FADE_STEP = 3'd3;
  localparam logic [2:0] REG_FADE_TCKS = 3'd4;
  localparam logic [2:0] REG_PWM_PER   = 3'd5;
  localparam logic [2:0] REG_CHAN_SEL  = 3'd6;

  // Register file contents seen by the datapath
  typedef struct packed {
    logic [BRT_W-1:0]  brt_min;
    logic [BRT_W-1:0]  brt_max;
    logic [BRT_W-1:0]  enc_step;
    logic [BRT_W-1:0]  fade_step;
    logic [WIDE_W-1:0] fade_ticks;
    logic [WIDE_W-1:0] pwm_top;
    logic              chan_sel;
  } cfg_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;    // capture the input beat
    logic mul;     // first product: level squared or delta times step
    logic scale;   // duty scaling product and encoder clamp
    logic commit;  // update strip state and load the output register
  } cmd_t;

endpackage

// ===== rtl/ldf_ctrl.sv =====
// Sequencer for the LED dimmer: handshakes and datapath commands.
`include "led_dimmer_fade_controller_assert.svh"

module ldf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ldf_pkg::cmd_t     cmd
);
  import ldf_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MUL   = 2'd1;
  localparam logic [1:0] S_SCALE = 2'd2;
  localparam logic [1:0] S_WB    = 2'd3;

  logic [1:0] seq;
  logic [1:0] seq_next;
  logic       out_free;

  assign in_ready = (seq == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Commands per step
  always_comb begin
    cmd.load   = in_valid && in_ready;
    cmd.mul    = (seq == S_MUL);
    cmd.scale  = (seq == S_SCALE);
    cmd.commit = (seq == S_WB) && out_free;
  end

  // Step sequence
  always_comb begin
    seq_next = seq;
    case (seq)
      S_IDLE:  if (in_valid) seq_next = S_MUL;
      S_MUL:   seq_next = S_SCALE;
      S_SCALE: seq_next = S_WB;
      S_WB:    if (out_free) seq_next = S_IDLE;
      default: seq_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= S_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  // Output beat holding register flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `LDF_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, seq == S_MUL)
  `LDF_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid)
  `LDF_ASSERT_NEXT(a_wb_waits, seq == S_WB && out_valid && !out_ready,
                   seq == S_WB && out_valid)
  `LDF_ASSERT_NOW(a_one_step, 1'b1,
                  $onehot0({cmd.load, cmd.mul, cmd.scale, cmd.commit}))

endmodule

// ===== rtl/ldf_dp.sv =====
// Datapath for the LED dimmer: strip state, products, clamp and output register.
module ldf_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   opcode,
  input  logic signed [7:0]            encoder_delta,
  input  ldf_pkg::cfg_t                cfg,
  input  ldf_pkg::cmd_t                cmd,
  output logic [ldf_pkg::WIDE_W-1:0]   duty,
  output logic                         duty_update,
  output logic                         channel,
  output logic [1:0]                   status,
  output logic [ldf_pkg::BRT_W-1:0]    brightness
);
  import ldf_pkg::*;

  // Captured beat
  logic [1:0]        op_q;
  logic signed [7:0] delta_q;

  // Strip state
  logic [1:0]        led_state;
  logic [BRT_W-1:0]  level;
  logic [WIDE_W-1:0] fade_timer;

  // Stage registers
  logic signed [25:0] prod_q;
  logic [28:0]        scale_q;
  logic [BRT_W-1:0]   enc_q;

  // Beat capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= opcode;
      delta_q <= encoder_delta;
    end
  end

  // First multiply: level squared, or encoder delta times step
  logic signed [12:0] mul_a;
  logic signed [12:0] mul_b;

  always_comb begin
    if (op_q == OP_ENC) begin
      mul_a = {{5{delta_q[7]}}, delta_q};
      mul_b = $signed({1'b0, cfg.enc_step});
    end else begin
      mul_a = $signed({1'b0, level});
      mul_b = $signed({1'b0, level});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Second multiply: duty base times period; encoder clamp alongside
  logic [BRT_W-1:0]   sq;
  logic [12:0]        base;
  logic signed [21:0] enc_b;
  logic signed [21:0] min_s;
  logic signed [21:0] max_s;
  logic [BRT_W-1:0]   enc_clamp;

  always_comb begin
    sq    = prod_q[FRAC_BITS+BRT_W-1:FRAC_BITS];
    base  = {1'b0, sq} + ((led_state == ST_ON) ? {1'b0, cfg.brt_min} : 13'd0);
    min_s = $signed({10'd0, cfg.brt_min});
    max_s = $signed({10'd0, cfg.brt_max});
    enc_b = $signed({10'd0, level}) - $signed(prod_q[21:0]);
    if (enc_b <= min_s) begin
      enc_clamp = cfg.brt_min;
    end else if (enc_b >= max_s) begin
      enc_clamp = cfg.brt_max;
    end else begin
      enc_clamp = enc_b[BRT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      scale_q <= base * cfg.pwm_top;
      enc_q   <= enc_clamp;
    end
  end

  // Saturated duty
  logic [WIDE_W-1:0] duty_sat;
  assign duty_sat = scale_q[28] ? {WIDE_W{1'b1}} : scale_q[27:FRAC_BITS];

  // Commit: next strip state and result beat
  logic [1:0]        led_state_next;
  logic [BRT_W-1:0]  level_next;
  logic [WIDE_W-1:0] fade_timer_next;
  logic [WIDE_W-1:0] duty_next;
  logic              update_next;

  always_comb begin
    led_state_next  = led_state;
    level_next      = level;
    fade_timer_next = fade_timer;
    duty_next       = '0;
    update_next     = 1'b0;
    case (op_q)
      OP_TICK: begin
        update_next = 1'b1;
        case (led_state)
          ST_OFF: begin
            level_next = cfg.brt_min;
          end
          ST_ON: begin
            duty_next = duty_sat;
          end
          ST_FADE: begin
            if (fade_timer >= cfg.fade_ticks) begin
              fade_timer_next = '0;
              led_state_next  = ST_OFF;
            end else begin
              fade_timer_next = fade_timer + 1'b1;
            end
            duty_next  = duty_sat;
            level_next = (level > cfg.fade_step) ? level - cfg.fade_step : '0;
          end
          default: ;
        endcase
      end
      OP_BUTTON: begin
        if (led_state == ST_OFF) begin
          led_state_next = ST_ON;
        end else if (led_state == ST_ON) begin
          led_state_next = ST_FADE;
        end
      end
      OP_ENC: begin
        if (led_state != ST_FADE) level_next = enc_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_state  <= ST_OFF;
      level      <= '0;
      fade_timer <= '0;
    end else if (cmd.commit) begin
      led_state  <= led_state_next;
      level      <= level_next;
      fade_timer <= fade_timer_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      duty        <= duty_next;
      duty_update <= update_next;
      channel     <= cfg.chan_sel;
      status      <= led_state_next;
      brightness  <= level_next;
    end
  end

endmodule

// ===== rtl/led_dimmer_fade_controller.sv =====
// LED dimmer fade controller: top level with configuration registers.
//
// Usage:
//   Event channel: in_valid/in_ready carry one event beat (opcode, encoder_delta):
//   tick, button press or encoder movement. Each accepted event yields exactly
//   one result beat on out_valid/out_ready (duty, duty_update, channel, status,
//   brightness).
//   Config channel: cfg_valid/cfg_ready write cfg_data into register cfg_index
//   (0 min, 1 max, 2 encoder step, 3 fade step, 4 fade ticks, 5 PWM period,
//   6 channel select); other indexes are dropped. cfg_ready is always high.
//   Write configuration only while no event is in flight.
//   Timing: the accepting edge captures the event; the result beat is presented
//   after the square/product multiply, the duty scaling multiply and the commit,
//   and the next event is accepted only once that commit has taken place.
//   Stall: the result sits in an output register; while the receiver holds
//   out_ready low the next event may be accepted and computed, and its commit
//   waits until the output register is taken.
//   Reset: synchronous, active high; strip off, level 0, fade timer 0,
//   registers at their defaults, no result pending.
module led_dimmer_fade_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic signed [7:0]            encoder_delta,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ldf_pkg::WIDE_W-1:0]   duty,
  output logic                         duty_update,
  output logic                         channel,
  output logic [1:0]                   status,
  output logic [ldf_pkg::BRT_W-1:0]    brightness,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [ldf_pkg::WIDE_W-1:0]   cfg_data
);
  import ldf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brt_min    <= 12'd0;
      cfg.brt_max    <= 12'd4095;
      cfg.enc_step   <= 12'd64;
      cfg.fade_step  <= 12'd16;
      cfg.fade_ticks <= 16'd100;
      cfg.pwm_top    <= 16'd1000;
      cfg.chan_sel   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BRT_MIN:   cfg.brt_min    <= cfg_data[BRT_W-1:0];
        REG_BRT_MAX:   cfg.brt_max    <= cfg_data[BRT_W-1:0];
        REG_ENC_STEP:  cfg.enc_step   <= cfg_data[BRT_W-1:0];
        REG_FADE_STEP: cfg.fade_step  <= cfg_data[BRT_W-1:0];
        REG_FADE_TCKS: cfg.fade_ticks <= cfg_data;
        REG_PWM_PER:   cfg.pwm_top    <= cfg_data;
        REG_CHAN_SEL:  cfg.chan_sel   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ldf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ldf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .opcode        (opcode),
    .encoder_delta (encoder_delta),
    .cfg           (cfg),
    .cmd           (cmd),
    .duty          (duty),
    .duty_update   (duty_update),
    .channel       (channel),
    .status        (status),
    .brightness    (brightness)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the LED dimmer fade controller.
`timescale 1ns / 1ps

module tb;
  import ldf_pkg::*;

  localparam int         CYCLE_LIMIT = 500_000;
  localparam int         LONG_HOLD   = 400;
  localparam logic [1:0] OP_NONE     = 2'd3;   // unused opcode
  localparam logic [2:0] REG_NONE    = 3'd7;   // index past the register list

  typedef struct packed {
    logic [1:0]        op;
    logic signed [7:0] delta;
  } ev_t;

  typedef struct packed {
    logic [WIDE_W-1:0] duty;
    logic              upd;
    logic              chan;
    logic [1:0]        status;
    logic [BRT_W-1:0]  brt;
  } dim_res_t;

  // DUT signals, all inputs known from time zero
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               opcode = OP_TICK;
  logic signed [7:0]        encoder_delta = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [WIDE_W-1:0]        duty;
  logic                     duty_update;
  logic                     channel;
  logic [1:0]               status;
  logic [BRT_W-1:0]         brightness;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [2:0]               cfg_index = '0;
  logic [WIDE_W-1:0]        cfg_data = '0;

  led_dimmer_fade_controller uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .encoder_delta(encoder_delta),
    .out_valid(out_valid), .out_ready(out_ready),
    .duty(duty), .duty_update(duty_update), .channel(channel),
    .status(status), .brightness(brightness),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the strip: registers and state
  cfg_t             shadow;
  logic [1:0]       strip_state;
  logic [BRT_W-1:0] level;
  logic [15:0]      fade_timer;

  ev_t      pending_events[$];
  dim_res_t expected_results[$];
  int       errors = 0;
  int       cycles = 0;
  logic     ev_fire = 1'b0;
  int       hold_asked = 0;
  int       hold_served = 0;

  // Duty scaling by the PWM period, saturating at 16 bits
  function automatic logic [15:0] scale_duty(longint base);
    longint d;
    d = (base * longint'(shadow.pwm_top)) >> FRAC_BITS;
    return (d > 65535) ? 16'hFFFF : d[15:0];
  endfunction

  // Advance the shadow strip by one event and return the result it gives
  function automatic dim_res_t dimmer_predict(ev_t e);
    dim_res_t r;
    longint   sq;
    int       b;
    r = '0;
    sq = (longint'(level) * longint'(level)) >> FRAC_BITS;
    case (e.op)
      OP_TICK: begin
        r.upd = 1'b1;
        if (strip_state == ST_OFF) begin
          level = shadow.brt_min;
        end else if (strip_state == ST_ON) begin
          r.duty = scale_duty(sq + longint'(shadow.brt_min));
        end else if (strip_state == ST_FADE) begin
          if (fade_timer >= shadow.fade_ticks) begin
            fade_timer  = '0;
            strip_state = ST_OFF;
          end else begin
            fade_timer = fade_timer + 16'd1;
          end
          r.duty = scale_duty(sq);
          level = (level > shadow.fade_step) ? level - shadow.fade_step : '0;
        end
      end
      OP_BUTTON: begin
        if (strip_state == ST_OFF) strip_state = ST_ON;
        else if (strip_state == ST_ON) strip_state = ST_FADE;
      end
      OP_ENC: begin
        if (strip_state != ST_FADE) begin
          b = int'(level) - int'($signed(e.delta)) * int'(shadow.enc_step);
          // min is tested first, then max
          if (b <= int'(shadow.brt_min)) b = int'(shadow.brt_min);
          else if (b >= int'(shadow.brt_max)) b = int'(shadow.brt_max);
          level = b[BRT_W-1:0];
        end
      end
      default: ;
    endcase
    r.chan   = shadow.chan_sel;
    r.status = strip_state;
    r.brt    = level;
    return r;
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Event driver: bursts of beats with random gaps
  always @(negedge clk) begin : ev_drv
    ev_t nxt;
    static int gap_left = 0;
    static int burst_left = 0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || ev_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        nxt = pending_events.pop_front();
        in_valid      <= 1'b1;
        opcode        <= nxt.op;
        encoder_delta <= nxt.delta;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern of its own, plus long holds on request
  always @(negedge clk) begin : res_rx
    logic rdy;
    static int hold_left = 0;
    static int rx_left = 0;
    static int rx_mode = 0;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = LONG_HOLD;
      rdy = 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 60);
      end
      rx_left--;
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = 1'b0;
      endcase
    end
    out_ready <= rdy;
  end

  // Monitor: check result beats, then predict for the accepted event beat
  always @(posedge clk) begin : mon
    dim_res_t want;
    ev_t      e;
    ev_fire <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, duty %0d status %0d brightness %0d",
                 $time, duty, status, brightness);
      end else begin
        want = expected_results.pop_front();
        check_field("duty", want.duty, duty);
        check_field("duty_update", want.upd, duty_update);
        check_field("channel", want.chan, channel);
        check_field("status", want.status, status);
        check_field("brightness", want.brt, brightness);
      end
    end
    if (!rst && in_valid && in_ready) begin
      e.op    = opcode;
      e.delta = encoder_delta;
      expected_results.push_back(dimmer_predict(e));
    end
  end

  task automatic push_ev(logic [1:0] op, logic signed [7:0] delta);
    pending_events.push_back(ev_t'{op: op, delta: delta});
  endtask

  // Sender pause: wait for every beat to go out and every result to come back
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
    #1;
  endtask

  task automatic reg_write(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BRT_MIN:   shadow.brt_min    = val[BRT_W-1:0];
      REG_BRT_MAX:   shadow.brt_max    = val[BRT_W-1:0];
      REG_ENC_STEP:  shadow.enc_step   = val[BRT_W-1:0];
      REG_FADE_STEP: shadow.fade_step  = val[BRT_W-1:0];
      REG_FADE_TCKS: shadow.fade_ticks = val;
      REG_PWM_PER:   shadow.pwm_top    = val;
      REG_CHAN_SEL:  shadow.chan_sel   = val[0];
      default: ;
    endcase
  endtask

  task automatic reg_done();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random register set with extremes mixed in; upper bits random to test masking
  task automatic random_config();
    logic [11:0] lo, hi;
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: begin lo = 12'd0;    hi = 12'd4095; end
      1: begin lo = 12'($urandom_range(0, 4095)); hi = 12'($urandom_range(0, 4095)); end
      default: begin
        lo = 12'($urandom_range(0, 1500));
        hi = 12'($urandom_range(2500, 4095));
      end
    endcase
    reg_write(REG_BRT_MIN, {4'($urandom), lo});
    reg_write(REG_BRT_MAX, {4'($urandom), hi});
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(0, 4))
        0: v[11:0] = 12'd0;
        1: v[11:0] = 12'd4095;
        default: v[11:0] = 12'($urandom_range(1, 300));
      endcase
      v[15:12] = 4'($urandom);
      reg_write((k == 0) ? REG_ENC_STEP : REG_FADE_STEP, v);
    end
    case ($urandom_range(0, 7))
      0: v = 16'd0;
      1: v = 16'hFFFF;
      default: v = 16'($urandom_range(0, 40));
    endcase
    reg_write(REG_FADE_TCKS, v);
    case ($urandom_range(0, 4))
      0: v = 16'd0;
      1: v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    reg_write(REG_PWM_PER, v);
    reg_write(REG_CHAN_SEL, 16'($urandom));
    if ($urandom_range(0, 1) == 0) reg_write(REG_NONE, 16'($urandom));
    reg_done();
  endtask

  // Event mix: mostly ticks and encoder moves, enough buttons to cycle the strip
  task automatic random_events(int n);
    int sel;
    logic signed [7:0] d;
    repeat (n) begin
      sel = $urandom_range(0, 19);
      d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($signed($urandom_range(0, 8)) - 4);
      if (sel < 10) push_ev(OP_TICK, d);
      else if (sel < 13) push_ev(OP_BUTTON, d);
      else if (sel < 19) push_ev(OP_ENC, d);
      else push_ev(OP_NONE, d);
    end
  endtask

  // Stimulus sequence
  initial begin
    shadow      = '{brt_min: 12'd0, brt_max: 12'd4095, enc_step: 12'd64, fade_step: 12'd16,
                    fade_ticks: 16'd100, pwm_top: 16'd1000, chan_sel: 1'b0};
    strip_state = ST_OFF;
    level       = '0;
    fade_timer  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Defaults: clamps both ways, full cycle off, on, fading, ignored events
    push_ev(OP_TICK, 8'sd0);
    push_ev(OP_NONE, -8'sd128);
    push_ev(OP_ENC, 8'sd127);
    push_ev(OP_ENC, -8'sd128);
    push_ev(OP_BUTTON, 8'sd0);
    push_ev(OP_TICK, 8'sd0);
    push_ev(OP_ENC, 8'sd1);
    push_ev(OP_BUTTON, -8'sd1);
    push_ev(OP_BUTTON, 8'sd0);
    push_ev(OP_ENC, -8'sd5);
    push_ev(OP_TICK, 8'sd0);
    push_ev(OP_TICK, 8'sd0);
    wait_idle();

    // All-ones registers: min above max, duty saturation, instant turn-off
    reg_write(REG_BRT_MIN, 16'hFFFF);
    reg_write(REG_BRT_MAX, 16'hF000);
    reg_write(REG_ENC_STEP, 16'hFFFF);
    reg_write(REG_FADE_STEP, 16'hFFFF);
    reg_write(REG_FADE_TCKS, 16'h0000);
    reg_write(REG_PWM_PER, 16'hFFFF);
    reg_write(REG_CHAN_SEL, 16'hFFFF);
    reg_write(REG_NONE, 16'hFFFF);
    reg_done();
    push_ev(OP_TICK, 8'sd0);
    push_ev(OP_BUTTON, 8'sd0);
    push_ev(OP_TICK, 8'sd0);
    push_ev(OP_ENC, 8'sd1);
    push_ev(OP_ENC, -8'sd128);
    push_ev(OP_BUTTON, 8'sd0);
    push_ev(OP_TICK, 8'sd0);
    push_ev(OP_TICK, 8'sd0);
    wait_idle();

    // Zero period and fade step, short fade that counts out
    reg_write(REG_BRT_MIN, 16'h0000);
    reg_write(REG_BRT_MAX, 16'h0FFF);
    reg_write(REG_ENC_STEP, 16'h0001);
    reg_write(REG_FADE_STEP, 16'h0000);
    reg_write(REG_FADE_TCKS, 16'h0002);
    reg_write(REG_PWM_PER, 16'h0000);
    reg_write(REG_CHAN_SEL, 16'h0000);
    reg_done();
    push_ev(OP_BUTTON, 8'sd0);
    push_ev(OP_BUTTON, 8'sd0);
    repeat (4) push_ev(OP_TICK, 8'sd0);
    wait_idle();

    // Random phases, one with a long receiver hold to back up the input
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      if (ph == 1) hold_asked++;
      random_events(250);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
